// File: rtl/core/quad_encoder_counter_4ch_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel quadrature counter
// Shared shorthand for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef QUAD_ENCODER_COUNTER_4CH_UNIT_MACROS_SVH
`define QUAD_ENCODER_COUNTER_4CH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QEC4_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("quadrature counter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QEC4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("quadrature counter check failed");

`endif

// File: rtl/core/qec4_pkg.sv
// ----------------------------------------------------------------------------
// qec4_pkg
// Types, constants and the transition table of the quadrature counter.
// ----------------------------------------------------------------------------
package qec4_pkg;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned INVERT_W  = NUM_CH;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned S_FIELD_W = NUM_CH * PHASE_W + 1;
  localparam int unsigned S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int unsigned M_FIELD_W = NUM_CH * CNT_W + 1;
  localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [INVERT_W-1:0] INVERT_RESET  = INVERT_W'(9);
  localparam logic [TICK_W-1:0]   DIVISOR_RESET = TICK_W'(100);

  typedef enum logic {
    REG_INVERT  = 1'b0,
    REG_DIVISOR = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // Per-tick control shared by all channel slices.
  typedef struct packed {
    logic accept;
    logic clear;
    logic captured;
  } chan_ctrl_t;

  // x4 decoding: one legal Gray-code step counts one, a double change counts none.
  function automatic step_e step_of(input logic [PHASE_W-1:0] prev,
                                    input logic [PHASE_W-1:0] cur);
    step_e s;
    unique case ({prev, cur})
      4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: s = STEP_UP;
      4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: s = STEP_DOWN;
      default:                                 s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/qec4_regs.sv
// ----------------------------------------------------------------------------
// qec4_regs
// Configuration registers behind the APB port: invert mask and beat divisor.
// ----------------------------------------------------------------------------
module qec4_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qec4_pkg::PADDR_W-1:0]      paddr,
  input  logic [qec4_pkg::PDATA_W-1:0]      pwdata,
  output logic [qec4_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic [qec4_pkg::INVERT_W-1:0]     invert_mask_o,
  output logic [qec4_pkg::TICK_W-1:0]       beat_divisor_o
);

  logic [qec4_pkg::INVERT_W-1:0] invert_q;
  logic [qec4_pkg::TICK_W-1:0]   divisor_q;
  qec4_pkg::reg_idx_e            idx;
  logic                          wr_en;

  assign idx    = qec4_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= qec4_pkg::INVERT_RESET;
      divisor_q <= qec4_pkg::DIVISOR_RESET;
    end else if (wr_en) begin
      unique case (idx)
        qec4_pkg::REG_INVERT:  invert_q  <= pwdata[qec4_pkg::INVERT_W-1:0];
        qec4_pkg::REG_DIVISOR: divisor_q <= pwdata[qec4_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      qec4_pkg::REG_INVERT:  prdata = qec4_pkg::PDATA_W'(invert_q);
      qec4_pkg::REG_DIVISOR: prdata = qec4_pkg::PDATA_W'(divisor_q);
      default:               prdata = '0;
    endcase
  end

  assign invert_mask_o  = invert_q;
  assign beat_divisor_o = divisor_q;

endmodule

// File: rtl/core/qec4_chan.sv
// ----------------------------------------------------------------------------
// qec4_chan
// One encoder slice: stored phase, transition decode and position counter.
// ----------------------------------------------------------------------------
module qec4_chan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qec4_pkg::chan_ctrl_t           ctrl_i,
  input  logic [qec4_pkg::PHASE_W-1:0]   phase_i,
  input  logic                           invert_i,
  output logic [qec4_pkg::CNT_W-1:0]     count_o
);

  logic [qec4_pkg::PHASE_W-1:0] prev_q;
  logic [qec4_pkg::CNT_W-1:0]   count_q, count_d, base;
  qec4_pkg::step_e              step;

  always_comb begin
    step = qec4_pkg::step_of(prev_q, phase_i);
    // The capture tick only records the phase.
    if (!ctrl_i.captured) begin
      step = qec4_pkg::STEP_NONE;
    end else if (invert_i) begin
      unique case (step)
        qec4_pkg::STEP_UP:   step = qec4_pkg::STEP_DOWN;
        qec4_pkg::STEP_DOWN: step = qec4_pkg::STEP_UP;
        default:             step = qec4_pkg::STEP_NONE;
      endcase
    end
  end

  always_comb begin
    base = ctrl_i.clear ? '0 : count_q;
    unique case (step)
      qec4_pkg::STEP_UP:   count_d = base + qec4_pkg::CNT_W'(1);
      qec4_pkg::STEP_DOWN: count_d = base - qec4_pkg::CNT_W'(1);
      default:             count_d = base;
    endcase
  end

  // The counter doubles as the result register: it moves only on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.accept) begin
      prev_q  <= phase_i;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/core/qec4_beat.sv
// ----------------------------------------------------------------------------
// qec4_beat
// Tick divider that flags a control beat once every divisor ticks (every tick for a divisor of 0).
// ----------------------------------------------------------------------------
module qec4_beat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [qec4_pkg::TICK_W-1:0]   divisor_i,
  output logic                          beat_o
);

  logic [qec4_pkg::TICK_W-1:0] tick_q;
  logic [qec4_pkg::TICK_W:0]   next;
  logic                        hit;
  logic                        beat_q;

  assign next = {1'b0, tick_q} + (qec4_pkg::TICK_W + 1)'(1);
  assign hit  = next >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      beat_q <= 1'b0;
    end else if (accept_i) begin
      tick_q <= hit ? '0 : next[qec4_pkg::TICK_W-1:0];
      beat_q <= hit;
    end
  end

  assign beat_o = beat_q;

endmodule

// File: rtl/core/quad_encoder_counter_4ch_unit.sv
// ----------------------------------------------------------------------------
// quad_encoder_counter_4ch_unit
// Four-channel x4 quadrature decoder with a control-beat tick divider.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one sample tick holding the A/B
//   phases of four encoders and a clear flag. Each tick produces exactly one
//   transfer on m_axis with all four 32-bit signed counts and the beat flag.
//   The result is valid in the cycle after the input transfer. Throughput
//   is one tick per cycle unless m_axis stalls; the counters and the phase
//   and tick registers form the result register and are updated in a single
//   pass of an increment/decrement per channel and a 16-bit compare.
//   s_axis_tready is high whenever no result is pending or the pending one is
//   taken in the same cycle, so a stall on m_axis holds the result stable and
//   keeps s_axis_tready low for as long as a result waits. Reset clears all
//   counts, phases and the tick divider, sets the invert mask to 9 and the
//   divisor to 100; the first tick after reset only captures the phases. The
//   user must write registers over APB while idle; the block does not check.
// ----------------------------------------------------------------------------
module quad_encoder_counter_4ch_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // phase_ch1, phase_ch2, phase_ch3, phase_ch4, clear_counts from bit 0 up
  input  logic [qec4_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // count_ch1, count_ch2, count_ch3, count_ch4, control_beat from bit 0 up
  output logic [qec4_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qec4_pkg::PADDR_W-1:0]      paddr,
  input  logic [qec4_pkg::PDATA_W-1:0]      pwdata,
  output logic [qec4_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [qec4_pkg::INVERT_W-1:0]                     invert_mask;
  logic [qec4_pkg::TICK_W-1:0]                       beat_divisor;
  logic [qec4_pkg::NUM_CH-1:0][qec4_pkg::CNT_W-1:0]  counts;
  logic                                              beat;
  logic                                              accept;
  logic                                              captured_q;
  logic                                              out_valid_q;
  qec4_pkg::chan_ctrl_t                              ctrl;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.accept   = accept;
  assign ctrl.clear    = s_axis_tdata[qec4_pkg::NUM_CH * qec4_pkg::PHASE_W];
  assign ctrl.captured = captured_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      captured_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        captured_q <= 1'b1;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  qec4_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .invert_mask_o  (invert_mask),
    .beat_divisor_o (beat_divisor)
  );

  for (genvar i = 0; i < qec4_pkg::NUM_CH; i++) begin : g_chan
    qec4_chan u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .phase_i  (s_axis_tdata[i*qec4_pkg::PHASE_W +: qec4_pkg::PHASE_W]),
      .invert_i (invert_mask[i]),
      .count_o  (counts[i])
    );
  end

  qec4_beat u_beat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .divisor_i (beat_divisor),
    .beat_o    (beat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = qec4_pkg::M_TDATA_W'({beat, counts});

endmodule

// File: rtl/core/qec4_checker.sv
// ----------------------------------------------------------------------------
// qec4_checker
// Port-level checks of the quadrature counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_encoder_counter_4ch_unit_macros.svh"

module qec4_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [qec4_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Every input transfer yields a result in the following cycle.
  `QEC4_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_xfer, m_axis_tvalid)

  // With no result pending, the input side is never stalled.
  `QEC4_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // A stalled result holds and nothing new is taken in.
  `QEC4_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_stall,
                    m_axis_tvalid && $stable(m_axis_tdata) && !$past(s_axis_tready))

  // Without a new input transfer, the result is not replaced.
  `QEC4_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, !in_xfer && !m_axis_tready,
                    $stable(m_axis_tvalid))

endmodule

bind quad_encoder_counter_4ch_unit qec4_checker u_qec4_checker (.*);

// File: dv/quad_encoder_counter_4ch_unit_checker.sv
// ----------------------------------------------------------------------------
// quad_encoder_counter_4ch_unit_checker
// Watches the sample, result and register channels of the quadrature counter,
// keeps its own model of the counters and the tick divider, and compares
// every result transfer field by field with the oldest predicted tick.
// ----------------------------------------------------------------------------
module quad_encoder_counter_4ch_unit_checker
  import qec4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  input  logic [PDATA_W-1:0]   prdata,
  input  logic                 pready,
  output int                   fails_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_CH-1:0][CNT_W-1:0] counts;
    logic                         beat;
  } tick_result_t;

  tick_result_t                 count_q[$];
  logic [PHASE_W-1:0]           last_phase [NUM_CH];
  logic                         captured;
  logic [NUM_CH-1:0][CNT_W-1:0] position;
  logic [TICK_W-1:0]            ticks;
  logic [INVERT_W-1:0]          invert;
  logic [TICK_W-1:0]            divisor;
  int                           fails = 0;
  int                           pending = 0;

  assign fails_o   = fails;
  assign pending_o = pending;

  // Rank of a phase along the Gray sequence; moving one rank down counts up.
  function automatic step_e decode_step(input logic [PHASE_W-1:0] prev,
                                        input logic [PHASE_W-1:0] cur);
    logic [1:0] delta;
    delta = {cur[1], ^cur} - {prev[1], ^prev};
    if (delta == 2'd3) return STEP_UP;
    if (delta == 2'd1) return STEP_DOWN;
    return STEP_NONE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t       got;
    tick_result_t       want;
    logic [PHASE_W-1:0] ph;
    step_e              st;
    logic [TICK_W:0]    next_tick;
    logic [PDATA_W-1:0] reg_val;
    if (!rst_ni) begin
      count_q.delete();
      for (int c = 0; c < NUM_CH; c++) last_phase[c] = '0;
      captured = 1'b0;
      position = '0;
      ticks    = '0;
      invert   = INVERT_RESET;
      divisor  = DIVISOR_RESET;
      pending  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.counts = m_axis_tdata[NUM_CH*CNT_W-1:0];
        got.beat   = m_axis_tdata[NUM_CH*CNT_W];
        if (count_q.size() == 0) begin
          $display("%0t: result transfer with no tick outstanding, data %h",
                   $time, m_axis_tdata);
          fails++;
        end else begin
          want = count_q.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (got.counts[c] !== want.counts[c]) begin
              $display("%0t: count_ch%0d expected %0d got %0d", $time, c + 1,
                       $signed(want.counts[c]), $signed(got.counts[c]));
              fails++;
            end
          end
          if (got.beat !== want.beat) begin
            $display("%0t: control_beat expected %0b got %0b", $time,
                     want.beat, got.beat);
            fails++;
          end
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          if (reg_idx_e'(paddr[2]) == REG_INVERT) invert = pwdata[INVERT_W-1:0];
          else divisor = pwdata[TICK_W-1:0];
        end else begin
          reg_val = (reg_idx_e'(paddr[2]) == REG_INVERT) ? PDATA_W'(invert)
                                                         : PDATA_W'(divisor);
          if (prdata !== reg_val) begin
            $display("%0t: register read at %0d expected %h got %h", $time,
                     paddr, reg_val, prdata);
            fails++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata[NUM_CH*PHASE_W]) position = '0;
        for (int c = 0; c < NUM_CH; c++) begin
          ph = s_axis_tdata[c*PHASE_W +: PHASE_W];
          if (captured) begin
            st = decode_step(last_phase[c], ph);
            if (invert[c]) begin
              st = (st == STEP_UP) ? STEP_DOWN : (st == STEP_DOWN) ? STEP_UP : STEP_NONE;
            end
            if (st == STEP_UP) position[c] = position[c] + 1'b1;
            else if (st == STEP_DOWN) position[c] = position[c] - 1'b1;
          end
          last_phase[c] = ph;
        end
        captured  = 1'b1;
        next_tick = {1'b0, ticks} + 1'b1;
        want.beat = (next_tick >= {1'b0, divisor});
        ticks     = want.beat ? '0 : next_tick[TICK_W-1:0];
        want.counts = position;
        count_q.push_back(want);
      end
      pending = count_q.size();
    end
  end

endmodule

// File: dv/quad_encoder_counter_4ch_unit_tb.sv
// ----------------------------------------------------------------------------
// quad_encoder_counter_4ch_unit_tb
// Drives encoder sample ticks and register writes into the quadrature
// counter with random gaps and back-pressure; a checker beside the block
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module quad_encoder_counter_4ch_unit_tb;
  import qec4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {MOVE_HOLD, MOVE_FWD, MOVE_BACK, MOVE_FLIP, MOVE_ANY} move_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   fails;
  int                   pending;

  logic [PHASE_W-1:0]   phase_now [NUM_CH];
  logic                 calm;
  int                   ticks_sent;
  int                   settings;

  quad_encoder_counter_4ch_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  quad_encoder_counter_4ch_unit_checker count_checker (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fails_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("quad_encoder_counter_4ch_unit_tb: FAIL");
    $finish;
  end

  // Result side: random stall bursts until the quiet tail of the run.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  function automatic logic [PHASE_W-1:0] move_phase(input logic [PHASE_W-1:0] p,
                                                    input move_e m);
    case (m)
      MOVE_FWD:  return (p == 2'd0) ? 2'd2 : (p == 2'd2) ? 2'd3 : (p == 2'd3) ? 2'd1 : 2'd0;
      MOVE_BACK: return (p == 2'd0) ? 2'd1 : (p == 2'd1) ? 2'd3 : (p == 2'd3) ? 2'd2 : 2'd0;
      MOVE_FLIP: return p ^ 2'b11;
      MOVE_ANY:  return PHASE_W'($urandom_range(0, 3));
      default:   return p;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic clr);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    for (int c = 0; c < NUM_CH; c++) word[c*PHASE_W +: PHASE_W] = phase_now[c];
    word[NUM_CH*PHASE_W] = clr;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic move_all(input move_e m, input logic clr);
    for (int c = 0; c < NUM_CH; c++) phase_now[c] = move_phase(phase_now[c], m);
    send_tick(clr);
  endtask

  task automatic random_tick();
    int r;
    for (int c = 0; c < NUM_CH; c++) begin
      r = $urandom_range(0, 99);
      phase_now[c] = move_phase(phase_now[c], r < 40 ? MOVE_FWD : r < 72 ? MOVE_BACK :
                                r < 84 ? MOVE_HOLD : r < 94 ? MOVE_FLIP : MOVE_ANY);
    end
    send_tick($urandom_range(0, 39) == 0);
  endtask

  // Drops the sample stream and lets every outstanding result drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e r, input logic wr, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [INVERT_W-1:0] mask, input logic [TICK_W-1:0] div);
    logic [PDATA_W-1:0] junk;
    junk = $urandom();
    apb_access(REG_INVERT, 1'b1, {junk[PDATA_W-1:INVERT_W], mask});
    junk = $urandom();
    apb_access(REG_DIVISOR, 1'b1, {junk[PDATA_W-1:TICK_W], div});
    apb_access(REG_INVERT, 1'b0, '0);
    apb_access(REG_DIVISOR, 1'b0, '0);
    settings++;
  endtask

  initial begin
    logic [INVERT_W-1:0] mask;
    logic [TICK_W-1:0]   div;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    ticks_sent    = 0;
    settings      = 1;
    phase_now     = '{2'd3, 2'd0, 2'd1, 2'd2};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apb_access(REG_INVERT, 1'b0, '0);
    apb_access(REG_DIVISOR, 1'b0, '0);

    // Directed ticks under the reset settings; the first one clears while
    // the phases are only being captured.
    send_tick(1'b1);
    repeat (4) move_all(MOVE_FWD, 1'b0);
    repeat (4) move_all(MOVE_BACK, 1'b0);
    move_all(MOVE_FLIP, 1'b0);
    move_all(MOVE_HOLD, 1'b0);
    move_all(MOVE_FWD, 1'b1);
    for (int k = 0; k < 3; k++) begin
      phase_now[0] = move_phase(phase_now[0], MOVE_FWD);
      phase_now[1] = move_phase(phase_now[1], MOVE_BACK);
      phase_now[2] = move_phase(phase_now[2], MOVE_FLIP);
      send_tick(1'b0);
    end
    repeat (3) move_all(MOVE_FWD, 1'b0);
    drain();

    // Random phases; the divisor drops far below the running tick count
    // when the third setting follows the largest divisor.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin mask = 4'b0000; div = 16'd1;     end
        1:       begin mask = 4'b1111; div = 16'd65535; end
        2:       begin mask = 4'b0101; div = 16'd3;     end
        3:       begin mask = INVERT_W'($urandom()); div = 16'd0; end
        4:       begin mask = INVERT_W'($urandom()); div = TICK_W'($urandom_range(2, 300)); end
        default: begin mask = 4'b1010; div = 16'd100;   end
      endcase
      configure(mask, div);
      calm = (p == 5);
      repeat (122) random_tick();
      drain();
    end

    $display("Covered %0d sample ticks under %0d register settings,", ticks_sent, settings);
    $display("including clears, double changes and divisor extremes.");
    if (fails == 0) begin
      $display("quad_encoder_counter_4ch_unit_tb: PASS");
    end else begin
      $display("quad_encoder_counter_4ch_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
